// ===== src/ssbc_pkg.sv =====
// Shared types, constants and the commutation tables of the six-step commutator.
// Used by the channel interfaces and by every module in src.
package ssbc_pkg;

    localparam int DUTY_WIDTH = 16;
    localparam int GATE_COUNT = 6;
    localparam int STEP_COUNT = 6;
    localparam int METHOD_COUNT = 5;
    localparam int TICK_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;

    // Result queue sizing
    localparam int RESULT_DEPTH = 3;
    localparam int RESULT_PTR_WIDTH = $clog2(RESULT_DEPTH);
    localparam int RESULT_CNT_WIDTH = $clog2(RESULT_DEPTH + 1);

    typedef logic [DUTY_WIDTH-1:0] t_duty;
    typedef logic [2:0]            t_step;
    typedef logic [2:0]            t_channel;
    typedef logic [TICK_WIDTH-1:0] t_tick;
    typedef logic [RESULT_PTR_WIDTH-1:0] t_res_ptr;
    typedef logic [RESULT_CNT_WIDTH-1:0] t_res_count;
    typedef logic [RESULT_CNT_WIDTH:0]   t_res_occ;

    // Operation codes carried by a command transaction
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_ALL = 2'd1,
        OP_SET_ONE = 2'd2,
        OP_SET_RUN = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROTATION_DIR = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIVE_METHOD = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FULL_DUTY    = 2'd3;

    // Reset values of the configuration registers
    localparam t_tick      PERIOD_RESET    = 8'd10;
    localparam logic       DIR_RESET       = 1'b0;
    localparam logic [2:0] METHOD_RESET    = 3'd0;
    localparam t_duty      FULL_DUTY_RESET = 16'd1000;
    localparam t_step      STEP_FIRST      = 3'd1;
    localparam t_step      STEP_LAST       = 3'd6;

    // What a table entry drives onto a gate
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_DUTY = 2'd2
    } t_kind;

    localparam t_kind Z = KIND_ZERO;
    localparam t_kind F = KIND_FULL;
    localparam t_kind D = KIND_DUTY;

    // Per method, per step, per gate (HA HB HC LA LB LC)
    localparam t_kind METHOD_TABLE [METHOD_COUNT][STEP_COUNT][GATE_COUNT] = '{
        '{ '{D,Z,Z,Z,F,Z}, '{D,Z,Z,Z,Z,F}, '{Z,D,Z,Z,Z,F},
           '{Z,D,Z,F,Z,Z}, '{Z,Z,D,F,Z,Z}, '{Z,Z,D,Z,F,Z} },
        '{ '{F,Z,Z,Z,D,Z}, '{F,Z,Z,Z,Z,D}, '{Z,F,Z,Z,Z,D},
           '{Z,F,Z,D,Z,Z}, '{Z,Z,F,D,Z,Z}, '{Z,Z,F,Z,D,Z} },
        '{ '{D,Z,Z,D,F,Z}, '{D,Z,Z,D,Z,F}, '{Z,D,Z,Z,D,F},
           '{Z,D,Z,F,D,Z}, '{Z,Z,D,F,Z,D}, '{Z,Z,D,Z,F,D} },
        '{ '{D,Z,Z,Z,D,Z}, '{D,Z,Z,Z,Z,D}, '{Z,D,Z,Z,Z,D},
           '{Z,D,Z,D,Z,Z}, '{Z,Z,D,D,Z,Z}, '{Z,Z,D,Z,D,Z} },
        '{ '{D,D,Z,D,D,Z}, '{D,Z,D,D,Z,D}, '{Z,D,D,Z,D,D},
           '{D,D,Z,D,D,Z}, '{D,Z,D,D,Z,D}, '{Z,D,D,Z,D,D} }
    };

    // Command payload
    typedef struct packed {
        t_op      op;
        t_channel channel;
        t_duty    duty_value;
        logic     run_request;
    } t_cmd;

    // Result payload
    typedef struct packed {
        t_duty gate_ha;
        t_duty gate_hb;
        t_duty gate_hc;
        t_duty gate_la;
        t_duty gate_lb;
        t_duty gate_lc;
        t_step step_now;
    } t_result;

    // Configuration register set
    typedef struct packed {
        t_tick      period_ticks;
        logic       rotation_dir;
        logic [2:0] drive_method;
        t_duty      full_duty;
    } t_cfg;

endpackage

// ===== src/ssbc_cmd_if.sv =====
// Command channel: valid/ready handshake with the command payload.
// Depends on ssbc_pkg for the field types.
interface ssbc_cmd_if;
    logic               valid;
    logic               ready;
    ssbc_pkg::t_op      op;
    ssbc_pkg::t_channel channel;
    ssbc_pkg::t_duty    duty_value;
    logic               run_request;

    modport source (output valid, output op, output channel, output duty_value,
                    output run_request, input ready);
    modport sink (input valid, input op, input channel, input duty_value,
                  input run_request, output ready);
endinterface

// ===== src/ssbc_res_if.sv =====
// Result channel: valid/ready handshake with six gate duties and the step.
// Depends on ssbc_pkg for the field types.
interface ssbc_res_if;
    logic            valid;
    logic            ready;
    ssbc_pkg::t_duty gate_ha;
    ssbc_pkg::t_duty gate_hb;
    ssbc_pkg::t_duty gate_hc;
    ssbc_pkg::t_duty gate_la;
    ssbc_pkg::t_duty gate_lb;
    ssbc_pkg::t_duty gate_lc;
    ssbc_pkg::t_step step_now;

    modport source (output valid, output gate_ha, output gate_hb, output gate_hc,
                    output gate_la, output gate_lb, output gate_lc, output step_now,
                    input ready);
    modport sink (input valid, input gate_ha, input gate_hb, input gate_hc,
                  input gate_la, input gate_lb, input gate_lc, input step_now,
                  output ready);
endinterface

// ===== src/six_step_bldc_commutator_unit.sv =====
// Six-step open-loop BLDC commutator, top level.
// Channels: i_cmd carries command transactions (tick, set all duties, set one
// duty, set run state); o_res carries result transactions with six gate duties
// (HA HB HC LA LB LC) and the step they belong to. Both use valid/ready and a
// transaction moves at a rising edge with valid and ready high. Configuration
// (period, direction, drive method, full duty) is written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must do so only while no transaction is in
// flight, which the block does not enforce. A command is registered at acceptance
// and processed from the input register; its result, if any, enters the three-entry
// queue and is driven on o_res. Throughput: one command per cycle while i_cmd.ready
// is high, set by the single pass through the commutation logic before the queue.
// While running, a tick ending the period or a stop gives one result; others none.
// Reset (synchronous, active low): step 1, tick count 0, stopped, stored duties
// zero, configuration at its defaults, queue empty.
// Receiver stall: up to three results wait in the queue; i_cmd.ready drops once
// the queue and the input register together could overflow it.
module six_step_bldc_commutator_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    ssbc_cmd_if.sink                                 i_cmd,
    ssbc_res_if.source                               o_res,
    input  logic                                     i_cfg_we,
    input  logic [ssbc_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  logic [ssbc_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data
);
    import ssbc_pkg::*;

    t_cfg       r_cfg;
    t_cmd       r_cmd;
    logic       r_cmd_valid;
    logic       core_res_valid;
    t_result    core_res;
    t_result    fifo_head;
    logic       fifo_valid;
    t_res_count fifo_count;
    t_res_occ   occupancy;
    logic       cmd_fire;

    // Accept while the queue can take every result still in flight
    assign occupancy   = {1'b0, fifo_count} + {{RESULT_CNT_WIDTH{1'b0}}, r_cmd_valid};
    assign i_cmd.ready = (occupancy <= t_res_occ'(RESULT_DEPTH - 1));
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks <= PERIOD_RESET;
            r_cfg.rotation_dir <= DIR_RESET;
            r_cfg.drive_method <= METHOD_RESET;
            r_cfg.full_duty    <= FULL_DUTY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD_TICKS: r_cfg.period_ticks <= i_cfg_data[TICK_WIDTH-1:0];
                CFG_ROTATION_DIR: r_cfg.rotation_dir <= i_cfg_data[0];
                CFG_DRIVE_METHOD: r_cfg.drive_method <= i_cfg_data[2:0];
                CFG_FULL_DUTY:    r_cfg.full_duty    <= i_cfg_data[DUTY_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register the accepted command transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= cmd_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_cmd.op          <= t_op'(i_cmd.op);
            r_cmd.channel     <= i_cmd.channel;
            r_cmd.duty_value  <= i_cmd.duty_value;
            r_cmd.run_request <= i_cmd.run_request;
        end
    end

    ssbc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (r_cmd_valid),
        .i_cmd       (r_cmd),
        .i_cfg       (r_cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    ssbc_result_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_res_valid),
        .i_data  (core_res),
        .i_pop   (o_res.ready),
        .o_valid (fifo_valid),
        .o_count (fifo_count),
        .o_data  (fifo_head)
    );

    // Drive the result channel from the queue head
    assign o_res.valid    = fifo_valid;
    assign o_res.gate_ha  = fifo_head.gate_ha;
    assign o_res.gate_hb  = fifo_head.gate_hb;
    assign o_res.gate_hc  = fifo_head.gate_hc;
    assign o_res.gate_la  = fifo_head.gate_la;
    assign o_res.gate_lb  = fifo_head.gate_lb;
    assign o_res.gate_lc  = fifo_head.gate_lc;
    assign o_res.step_now = fifo_head.step_now;

endmodule

// ===== src/ssbc_core.sv =====
// Commutation state and single-pass processing of one registered command.
// Holds tick count, step, run flag and stored gate duties; uses ssbc_pkg.
module ssbc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  ssbc_pkg::t_cmd   i_cmd,
    input  ssbc_pkg::t_cfg   i_cfg,
    output logic             o_res_valid,
    output ssbc_pkg::t_result o_res
);
    import ssbc_pkg::*;

    t_tick r_tick_count, n_tick_count;
    t_step r_step_index, n_step_index;
    logic  r_running, n_running;
    t_duty r_gate_duty [GATE_COUNT];
    t_duty n_gate_duty [GATE_COUNT];

    t_tick tick_inc;
    logic  emit_table;
    logic  emit_zero;
    t_step step_ofs;
    t_duty gate_out [GATE_COUNT];
    t_kind kind;

    // Work out the next state for the command held in the input register
    always_comb begin
        n_tick_count = r_tick_count;
        n_step_index = r_step_index;
        n_running    = r_running;
        n_gate_duty  = r_gate_duty;
        emit_table   = 1'b0;
        emit_zero    = 1'b0;
        tick_inc     = r_tick_count + t_tick'(1);
        if (i_cmd_valid) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_running) begin
                        if (tick_inc < i_cfg.period_ticks) begin
                            n_tick_count = tick_inc;
                        end else begin
                            n_tick_count = '0;
                            emit_table   = 1'b1;
                            if (!i_cfg.rotation_dir) begin
                                n_step_index = (r_step_index >= STEP_LAST) ? STEP_FIRST
                                                                           : r_step_index + t_step'(1);
                            end else begin
                                n_step_index = (r_step_index <= STEP_FIRST) ? STEP_LAST
                                                                            : r_step_index - t_step'(1);
                            end
                        end
                    end
                end
                OP_SET_ALL: begin
                    if (r_running) begin
                        for (int g = 0; g < GATE_COUNT; g++) begin
                            n_gate_duty[g] = i_cmd.duty_value;
                        end
                    end
                end
                OP_SET_ONE: begin
                    if (i_cmd.channel < t_channel'(GATE_COUNT)) begin
                        n_gate_duty[i_cmd.channel] = i_cmd.duty_value;
                    end
                end
                OP_SET_RUN: begin
                    if (i_cmd.run_request != r_running) begin
                        n_running = i_cmd.run_request;
                        if (!i_cmd.run_request) begin
                            emit_zero = 1'b1;
                            for (int g = 0; g < GATE_COUNT; g++) begin
                                n_gate_duty[g] = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Select each gate's duty from the method table for the new step
    assign step_ofs = n_step_index - t_step'(1);

    always_comb begin
        kind = KIND_ZERO;
        for (int g = 0; g < GATE_COUNT; g++) begin
            gate_out[g] = '0;
            if (emit_table && i_cfg.drive_method < 3'(METHOD_COUNT)) begin
                kind = METHOD_TABLE[i_cfg.drive_method][step_ofs][g];
                case (kind)
                    KIND_FULL: gate_out[g] = i_cfg.full_duty;
                    KIND_DUTY: gate_out[g] = r_gate_duty[g];
                    default:   gate_out[g] = '0;
                endcase
            end
        end
    end

    assign o_res_valid      = emit_table || emit_zero;
    assign o_res.gate_ha    = gate_out[0];
    assign o_res.gate_hb    = gate_out[1];
    assign o_res.gate_hc    = gate_out[2];
    assign o_res.gate_la    = gate_out[3];
    assign o_res.gate_lb    = gate_out[4];
    assign o_res.gate_lc    = gate_out[5];
    assign o_res.step_now   = n_step_index;

    // Hold the commutation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_step_index <= STEP_FIRST;
            r_running    <= 1'b0;
            for (int g = 0; g < GATE_COUNT; g++) begin
                r_gate_duty[g] <= '0;
            end
        end else begin
            r_tick_count <= n_tick_count;
            r_step_index <= n_step_index;
            r_running    <= n_running;
            r_gate_duty  <= n_gate_duty;
        end
    end

endmodule

// ===== src/ssbc_result_fifo.sv =====
// Three-entry result queue between the processing stage and the result channel.
// Absorbs results while the receiver stalls; uses ssbc_pkg for the payload type.
module ssbc_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ssbc_pkg::t_result    i_data,
    input  logic                 i_pop,
    output logic                 o_valid,
    output ssbc_pkg::t_res_count o_count,
    output ssbc_pkg::t_result    o_data
);
    import ssbc_pkg::*;

    t_result    r_slot [RESULT_DEPTH];
    t_res_ptr   r_wr_ptr, n_wr_ptr;
    t_res_ptr   r_rd_ptr, n_rd_ptr;
    t_res_count r_count, n_count;
    logic       do_pop;

    assign o_valid = (r_count != '0);
    assign o_count = r_count;
    assign o_data  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == t_res_ptr'(RESULT_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + t_res_ptr'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == t_res_ptr'(RESULT_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + t_res_ptr'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + t_res_count'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - t_res_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
